### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define HCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off while reset is asserted.
`define HCB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hcb_pkg.sv
// ---------------------------------------------------------------------------
// hcb_pkg
// Types, constants and the microcode table of the Hebbian context bias block.
// ---------------------------------------------------------------------------
package hcb_pkg;

    localparam int NUM_SLOTS   = 6;
    localparam int NUM_SENSORS = 5;
    localparam int DATA_W      = 16;
    localparam int THR_W       = 14;
    localparam int LR_W        = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int MASK_W      = 6;
    localparam int STEP_W      = 3;
    localparam int SUM_W       = 24;
    localparam int S_TDATA_W   = 176;
    localparam int M_TDATA_W   = 104;

    localparam logic [THR_W-1:0] THR_RESET = 14'd2458;
    localparam logic [LR_W-1:0]  LR_RESET  = 16'd197;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_THRESHOLD = 1'b0,
        CFG_LEARN_RATE       = 1'b1
    } hcb_cfg_idx_t;

    // Product selected for the lane multiplier in one step.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_PP,   // weight * weight
        MUL_ES,   // error * sensor
        MUL_LA,   // learn_rate * a
        MUL_AF,   // (learn_rate * a) * f
        MUL_PS    // new weight * sensor
    } hcb_mul_t;

    // Jump condition: when true the sequencer jumps to the target step.
    typedef enum logic [1:0] {
        JC_NEVER,
        JC_NO_INPUT,
        JC_OUT_BUSY
    } hcb_jc_t;

    typedef struct packed {
        hcb_mul_t          mul_sel;
        logic              ld_f;
        logic              ld_a;
        logic              ld_p;
        logic              ld_out;
        hcb_jc_t           cond;
        logic [STEP_W-1:0] target;
    } hcb_uword_t;

    // Control bundle from the sequencer to each lane.
    typedef struct packed {
        logic     go;
        hcb_mul_t mul_sel;
        logic     ld_f;
        logic     ld_a;
        logic     ld_p;
    } hcb_ctrl_t;

    // Microprogram. Step 0 waits for an input transfer and squares the
    // weight as it takes one, step 7 waits for room in the output register;
    // the counter then wraps to step 0.
    function automatic hcb_uword_t ucode(input logic [STEP_W-1:0] step);
        hcb_uword_t uw;
        uw.mul_sel = MUL_NONE;
        uw.ld_f    = 1'b0;
        uw.ld_a    = 1'b0;
        uw.ld_p    = 1'b0;
        uw.ld_out  = 1'b0;
        uw.cond    = JC_NEVER;
        uw.target  = step;
        case (step)
            3'd0: begin
                uw.mul_sel = MUL_PP;
                uw.cond    = JC_NO_INPUT;
            end
            3'd1: begin
                uw.ld_f    = 1'b1;
                uw.mul_sel = MUL_ES;
            end
            3'd2: begin
                uw.ld_a    = 1'b1;
            end
            3'd3: begin
                uw.mul_sel = MUL_LA;
            end
            3'd4: begin
                uw.mul_sel = MUL_AF;
            end
            3'd5: begin
                uw.ld_p = 1'b1;
            end
            3'd6: begin
                uw.mul_sel = MUL_PS;
            end
            3'd7: begin
                uw.ld_out = 1'b1;
                uw.cond   = JC_OUT_BUSY;
            end
            default: begin
                uw.cond = JC_NEVER;
            end
        endcase
        return uw;
    endfunction

    // Motors 0 and 1 share sensor 0; motor i above that uses sensor i-1.
    function automatic int sensor_of(input int motor);
        return (motor < 2) ? 0 : motor - 1;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] x);
        logic signed [DATA_W-1:0] y;
        if (x > SUM_W'(32767)) begin
            y = 16'sh7fff;
        end else if (x < -SUM_W'(32768)) begin
            y = 16'sh8000;
        end else begin
            y = x[DATA_W-1:0];
        end
        return y;
    endfunction

endpackage

### hw/rtl/hcb_lane.sv
// ---------------------------------------------------------------------------
// hcb_lane
// One motor's datapath: weight register, one shared multiplier, rounding.
// ---------------------------------------------------------------------------
module hcb_lane import hcb_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  hcb_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] err,
    input  logic signed [DATA_W-1:0] sens,
    input  logic [LR_W-1:0]          learn_rate,
    output logic signed [DATA_W-1:0] hebb_out
);

    localparam int OPA_W  = 35;
    localparam int OPB_W  = 18;
    localparam int PROD_W = OPA_W + OPB_W;

    localparam logic signed [PROD_W-1:0] HALF14 = PROD_W'(8192);
    localparam logic signed [PROD_W-1:0] HALF30 = PROD_W'(536870912);
    localparam logic signed [PROD_W-1:0] ONE_Q14 = PROD_W'(16384);

    logic signed [DATA_W-1:0] p_reg;
    logic signed [OPB_W-1:0]  f_reg;
    logic signed [OPB_W-1:0]  a_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [OPA_W-1:0]  opa;
    logic signed [OPB_W-1:0]  opb;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] sum14;
    logic signed [PROD_W-1:0] sum30;
    logic signed [PROD_W-1:0] rnd14;
    logic signed [PROD_W-1:0] rnd30;
    logic signed [SUM_W-1:0]  upd_sum;
    logic signed [DATA_W-1:0] p_next;

    always_comb begin
        case (ctrl.mul_sel)
            MUL_PP: begin
                opa = OPA_W'(p_reg);
                opb = OPB_W'(p_reg);
            end
            MUL_ES: begin
                opa = OPA_W'(err);
                opb = OPB_W'(sens);
            end
            MUL_LA: begin
                opa = OPA_W'(a_reg);
                opb = $signed({2'b00, learn_rate});
            end
            MUL_AF: begin
                opa = prod_reg[OPA_W-1:0];
                opb = f_reg;
            end
            MUL_PS: begin
                opa = OPA_W'(p_reg);
                opb = OPB_W'(sens);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign prod_next = opa * opb;

    // Round half up: add half an LSB, then arithmetic shift.
    assign sum14   = prod_reg + HALF14;
    assign sum30   = prod_reg + HALF30;
    assign rnd14   = sum14 >>> 14;
    assign rnd30   = sum30 >>> 30;
    assign upd_sum = SUM_W'(p_reg) + $signed(rnd30[SUM_W-1:0]);
    assign p_next  = sat16(upd_sum);

    assign hebb_out = sat16($signed(rnd14[SUM_W-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= '0;
        end else if (ctrl.go && ctrl.ld_p) begin
            p_reg <= p_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.go && (ctrl.mul_sel != MUL_NONE)) begin
            prod_reg <= prod_next;
        end
        if (ctrl.go && ctrl.ld_f) begin
            f_reg <= OPB_W'(ONE_Q14 - rnd14);
        end
        if (ctrl.go && ctrl.ld_a) begin
            a_reg <= rnd14[OPB_W-1:0];
        end
    end

endmodule

### hw/rtl/hebbian_context_bias.sv
// ---------------------------------------------------------------------------
// hebbian_context_bias
// Hebbian context bias with weight decay for up to six motors.
// ---------------------------------------------------------------------------
// Each input transfer carries six motor prediction errors and five context
// sensor readings (all Q2.14); each produces exactly one result transfer with
// six weight-times-sensor outputs and a six-bit release mask. The step that
// takes the transfer in also squares the weight, then seven more steps of a
// microcode program drive one multiplier per motor lane through the rest of
// its products (err*s, rate*a, that times f, new p times s). The result
// lands in an output register; the next item is taken while it waits, and
// the program only stalls in its last step if the previous result has not
// been taken yet. Weights and sensor flags reset to zero; there is no
// clearing pass. Configuration writes (threshold, learning rate) are taken
// at any clock edge and should only be issued while the block is idle.
// ---------------------------------------------------------------------------
module hebbian_context_bias import hcb_pkg::*; #(
    parameter int MOTORS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // error_0..error_5 at [95:0], ir_0..ir_4 at [175:96], 16 bits each
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // hebb_out_0..hebb_out_5 at [95:0], release_mask at [101:96], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    // Configuration
    logic [THR_W-1:0] thr_reg;
    logic [LR_W-1:0]  lr_reg;

    // Sequencer
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    hcb_uword_t        uw;
    hcb_ctrl_t         ctrl;
    logic              s_fire;
    logic              out_free;
    logic              jump;

    // Per-item state
    logic signed [DATA_W-1:0] err_reg  [NUM_SLOTS];
    logic signed [DATA_W-1:0] sens_reg [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]   active_reg;
    logic [NUM_SENSORS-1:0]   fell_reg;
    logic [NUM_SENSORS-1:0]   below;

    logic signed [DATA_W-1:0] lane_out [NUM_SLOTS];
    logic [MASK_W-1:0]        mask;
    logic [M_TDATA_W-1:0]     m_word;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     m_tvalid_reg;

    // ------------------------------------------------------------------
    // Microcode sequencer: fetch the control word for the current step,
    // hold at a step while its jump condition is true.
    // ------------------------------------------------------------------
    assign uw       = ucode(step_reg);
    assign s_tready = (uw.cond == JC_NO_INPUT);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        case (uw.cond)
            JC_NO_INPUT: jump = !s_fire;
            JC_OUT_BUSY: jump = !out_free;
            default:     jump = 1'b0;
        endcase
        // advance; the last step wraps back to the idle step
        step_next = jump ? uw.target : step_reg + STEP_W'(1);
    end

    assign ctrl.go      = !jump;
    assign ctrl.mul_sel = uw.mul_sel;
    assign ctrl.ld_f    = uw.ld_f;
    assign ctrl.ld_a    = uw.ld_a;
    assign ctrl.ld_p    = uw.ld_p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration writes; an unknown index is dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
            lr_reg  <= LR_RESET;
        end else if (cfg_we) begin
            case (hcb_cfg_idx_t'(cfg_index))
                CFG_SENSOR_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_LEARN_RATE:       lr_reg  <= cfg_wdata[LR_W-1:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input capture: threshold the sensors (signed compare, so negative
    // readings always read as zero) and note active-to-inactive falls.
    // ------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < NUM_SENSORS; k++) begin
            below[k] = $signed(s_tdata[(NUM_SLOTS + k) * DATA_W +: DATA_W])
                       < $signed({2'b00, thr_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (s_fire) begin
            active_reg <= ~below;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                err_reg[i] <= s_tdata[i * DATA_W +: DATA_W];
            end
            for (int k = 0; k < NUM_SENSORS; k++) begin
                sens_reg[k] <= below[k] ? '0
                             : s_tdata[(NUM_SLOTS + k) * DATA_W +: DATA_W];
            end
            fell_reg <= active_reg & below;
        end
    end

    // ------------------------------------------------------------------
    // Motor lanes; slots at or above MOTORS read as zero.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
        if (i < MOTORS) begin : g_lane
            hcb_lane u_lane (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .err        (err_reg[i]),
                .sens       (sens_reg[sensor_of(i)]),
                .learn_rate (lr_reg),
                .hebb_out   (lane_out[i])
            );
            assign mask[i] = fell_reg[sensor_of(i)];
        end else begin : g_off
            assign lane_out[i] = '0;
            assign mask[i]     = 1'b0;
        end
    end

    always_comb begin
        m_word = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            m_word[i * DATA_W +: DATA_W] = lane_out[i];
        end
        m_word[NUM_SLOTS * DATA_W +: MASK_W] = mask;
    end

    // ------------------------------------------------------------------
    // Output register: load in the last step, hold until the transfer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (uw.ld_out && ctrl.go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (uw.ld_out && ctrl.go) begin
            m_tdata_reg <= m_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hw/rtl/hcb_checker.sv
// ---------------------------------------------------------------------------
// hcb_checker
// Port-level assertions for the Hebbian context bias block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hcb_checker import hcb_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // An accepted item keeps the input closed while the program runs.
    `HCB_ASSERT_NXT(a_ready_drops, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready high after input transfer")
    `HCB_ASSERT_IMP(a_busy_span, aclk, aresetn, s_tvalid && s_tready, ##7 !s_tready, "input reopened before the last step")
    // A fresh result must trace back to an accepted input.
    `HCB_ASSERT_IMP(a_result_latency, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 8), "result without matching input")
    `HCB_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind hebbian_context_bias hcb_checker u_hcb_checker (.*);
